[hw/rtl/rtcm3_dfr_pkg.sv]
// Shared types, constants and the byte-wise CRC-24Q step for the RTCM v3 deframer.
// No dependencies; imported by rtcm3_frame_deframer_unit.
package rtcm3_dfr_pkg;

  // field widths
  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 10;
  localparam int MSG_W         = 12;
  localparam int CRC_W         = 24;
  localparam int FRAME_COUNT_W = 16;
  localparam int ERR_W         = 3;
  localparam int IDX_W         = 11;
  localparam int TDATA_W       = 72;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  // default width of the good-frame counter
  localparam int COUNT_BITS_DEF = 16;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // CRC-24Q
  localparam logic [CRC_W-1:0] CRC_POLY    = 24'h864CFB;
  localparam logic [1:0]       LEN_HI_MASK = 2'b11;

  // frame header positions
  localparam logic [IDX_W-1:0] IDX_PREAMBLE = 11'd0;
  localparam logic [IDX_W-1:0] IDX_LEN_HI   = 11'd1;
  localparam logic [IDX_W-1:0] IDX_LEN_LO   = 11'd2;
  localparam logic [IDX_W-1:0] IDX_MSG_HI   = 11'd3;
  localparam logic [IDX_W-1:0] IDX_MSG_LO   = 11'd4;
  localparam logic [IDX_W-1:0] HDR_BYTES    = 11'd3;
  localparam logic [IDX_W-1:0] OVERHEAD     = 11'd6;
  localparam logic [IDX_W-1:0] MIN_FRAME    = 11'd7;

  // register indexes
  localparam logic REG_SYNC_BYTE  = 1'b0;
  localparam logic REG_MAX_LENGTH = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_BYTE_RST  = 8'd211;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 10'd1023;

  // result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_PREAMBLE = 3'd2,
    ERR_LENGTH   = 3'd3,
    ERR_TRUNC    = 3'd4,
    ERR_CRC      = 3'd5
  } err_t;

  // one queued result beat
  typedef struct packed {
    logic                kind;
    logic [TDATA_W-1:0]  data;
    logic                last;
  } res_t;

  // one byte through the CRC-24Q register, msb first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 16'h0000};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // pack the result fields into tdata, lowest field first
  function automatic logic [TDATA_W-1:0] pack_data(input logic [LEN_W-1:0] len,
                                                   input logic [MSG_W-1:0] mt,
                                                   input logic [CRC_W-1:0] crc,
                                                   input logic [FRAME_COUNT_W-1:0] cnt,
                                                   input err_t err);
    return {7'b0, err, cnt, crc, mt, len};
  endfunction

endpackage

[hw/rtl/rtcm3_frame_deframer_unit.sv]
// RTCM v3 deframer top level: byte parser, CRC-24Q check and result queue.
// Depends on rtcm3_dfr_pkg.
// Results of an accepted byte enter the result queue and reach m_* behind any results still queued.
// Throughput: one byte per cycle; the byte CRC step is one unrolled XOR network.
// s_tready drops while the 4-entry result queue holds more than two results,
// since one byte can give a frame result and a done result.
// Reset (rst, synchronous) empties the queue, clears the parser and loads 211 / 1023.
module rtcm3_frame_deframer_unit
  import rtcm3_dfr_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
  input  logic                s_tlast,   // end_of_buffer
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [TDATA_W-1:0]  m_tdata,   // [9:0] payload_length, [21:10] msg_type,
                                         // [45:22] frame_crc, [61:46] frame_count,
                                         // [64:62] error_code, [71:65] zero
  output logic                m_tuser,   // kind
  output logic                m_tlast,   // last_result
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int CntW = (COUNT_BITS > FRAME_COUNT_W) ? FRAME_COUNT_W : COUNT_BITS;

  typedef enum logic {PH_RUN, PH_STOP} phase_t;

  // configuration registers
  logic [BYTE_W-1:0] sync_byte;
  logic [LEN_W-1:0]  max_length;
  logic              apb_write;

  assign pready    = 1'b1;
  assign apb_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte  <= SYNC_BYTE_RST;
      max_length <= MAX_LENGTH_RST;
    end else if (apb_write) begin
      if (paddr[2] == REG_SYNC_BYTE) begin
        sync_byte <= pwdata[BYTE_W-1:0];
      end else begin
        max_length <= pwdata[LEN_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_SYNC_BYTE) begin
      prdata = {{(PDATA_W-BYTE_W){1'b0}}, sync_byte};
    end else begin
      prdata = {{(PDATA_W-LEN_W){1'b0}}, max_length};
    end
  end

  // parser state
  phase_t            phase, phase_next;
  logic [IDX_W-1:0]  byte_index, byte_index_next;
  logic [LEN_W-1:0]  frame_len, frame_len_next;
  logic [CRC_W-1:0]  crc_acc, crc_acc_next;
  logic [CRC_W-1:0]  crc_received, crc_received_next;
  logic [MSG_W-1:0]  msg_type_reg, msg_type_reg_next;
  logic [CntW-1:0]   good_frames, good_frames_next;
  err_t              pending_error, pending_error_next;

  logic              s_accept;
  logic              frame_ok;
  logic [IDX_W-1:0]  body;
  res_t              frame_res, done_res;
  err_t              done_err;

  assign s_accept = s_tvalid && s_tready;

  // per-byte parse step
  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    frame_len_next     = frame_len;
    crc_acc_next       = crc_acc;
    crc_received_next  = crc_received;
    msg_type_reg_next  = msg_type_reg;
    good_frames_next   = good_frames;
    pending_error_next = pending_error;
    frame_ok           = 1'b0;
    body               = HDR_BYTES + IDX_W'(frame_len);
    frame_res          = '0;

    if (phase == PH_RUN) begin
      // header fields
      if (byte_index == IDX_PREAMBLE) begin
        if (s_tdata != sync_byte) begin
          pending_error_next = ERR_PREAMBLE;
        end
      end else if (byte_index == IDX_LEN_HI) begin
        frame_len_next = {s_tdata[1:0] & LEN_HI_MASK, 8'h00};
      end else if (byte_index == IDX_LEN_LO) begin
        frame_len_next = {frame_len[LEN_W-1:BYTE_W], s_tdata};
        if (pending_error_next == ERR_NONE &&
            (frame_len_next == '0 || frame_len_next > max_length)) begin
          pending_error_next = ERR_LENGTH;
        end
        body = HDR_BYTES + IDX_W'(frame_len_next);
      end

      // header and payload go through the crc, the trailer is collected
      if (byte_index < HDR_BYTES || byte_index < body) begin
        crc_acc_next = crc_byte(crc_acc, s_tdata);
        if (byte_index == IDX_MSG_HI) begin
          msg_type_reg_next = {s_tdata, 4'h0};
        end else if (byte_index == IDX_MSG_LO) begin
          msg_type_reg_next = {msg_type_reg[MSG_W-1:4], s_tdata[7:4]};
        end
      end else begin
        crc_received_next = {crc_received[CRC_W-BYTE_W-1:0], s_tdata};
      end

      byte_index_next = byte_index + 1'b1;

      // held error becomes final, or the frame closes
      if (byte_index_next == MIN_FRAME && pending_error_next != ERR_NONE) begin
        phase_next = PH_STOP;
      end else if (pending_error_next == ERR_NONE && byte_index_next >= HDR_BYTES &&
                   byte_index_next == OVERHEAD + IDX_W'(frame_len_next)) begin
        if (crc_received_next == crc_acc_next) begin
          frame_ok = 1'b1;
          if (good_frames != '1) begin
            good_frames_next = good_frames + 1'b1;
          end
          frame_res.kind = KIND_FRAME;
          frame_res.last = !s_tlast;
          frame_res.data = pack_data(frame_len_next,
                                     (frame_len_next >= LEN_W'(2)) ? msg_type_reg_next
                                                                   : '0,
                                     crc_received_next,
                                     FRAME_COUNT_W'(good_frames_next),
                                     ERR_NONE);
          byte_index_next    = '0;
          frame_len_next     = '0;
          crc_acc_next       = '0;
          crc_received_next  = '0;
          msg_type_reg_next  = '0;
          pending_error_next = ERR_NONE;
        end else begin
          pending_error_next = ERR_CRC;
          phase_next         = PH_STOP;
        end
      end
    end

    // end of buffer summary
    if (phase_next == PH_STOP) begin
      done_err = pending_error_next;
    end else if (byte_index_next == '0) begin
      done_err = ERR_NONE;
    end else if (byte_index_next < MIN_FRAME) begin
      done_err = ERR_SHORT;
    end else begin
      done_err = ERR_TRUNC;
    end
    done_res.kind = KIND_DONE;
    done_res.last = 1'b1;
    done_res.data = pack_data('0, '0, '0, FRAME_COUNT_W'(good_frames_next), done_err);

    if (s_tlast) begin
      phase_next         = PH_RUN;
      byte_index_next    = '0;
      frame_len_next     = '0;
      crc_acc_next       = '0;
      crc_received_next  = '0;
      msg_type_reg_next  = '0;
      pending_error_next = ERR_NONE;
      good_frames_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RUN;
      byte_index    <= '0;
      frame_len     <= '0;
      crc_acc       <= '0;
      crc_received  <= '0;
      msg_type_reg  <= '0;
      good_frames   <= '0;
      pending_error <= ERR_NONE;
    end else if (s_accept) begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      frame_len     <= frame_len_next;
      crc_acc       <= crc_acc_next;
      crc_received  <= crc_received_next;
      msg_type_reg  <= msg_type_reg_next;
      good_frames   <= good_frames_next;
      pending_error <= pending_error_next;
    end
  end

  // result queue, up to two pushes and one pop per cycle
  res_t              q_mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] q_count;
  logic [1:0]        n_push;
  logic              pop;
  res_t              push0, push1;

  assign n_push   = s_accept ? ({1'b0, frame_ok} + {1'b0, s_tlast}) : 2'd0;
  assign push0    = frame_ok ? frame_res : done_res;
  assign push1    = done_res;
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (q_count <= QCNT_W'(Q_DEPTH - 2));
  assign m_tvalid = (q_count != '0);
  assign m_tdata  = q_mem[rd_ptr].data;
  assign m_tuser  = q_mem[rd_ptr].kind;
  assign m_tlast  = q_mem[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem[wr_ptr] <= push0;
    end
    if (n_push == 2'd2) begin
      q_mem[wr_ptr + 1'b1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + QPTR_W'(n_push);
      rd_ptr  <= rd_ptr + QPTR_W'(pop);
      q_count <= q_count + QCNT_W'(n_push) - QCNT_W'(pop);
    end
  end

  // checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  a_buffer_restart: assert property (@(posedge clk) disable iff (rst)
    s_accept && s_tlast |=> byte_index == '0 && good_frames == '0 && phase == PH_RUN)
    else $error("parser not cleared after end of buffer");

  a_no_frame_when_stopped: assert property (@(posedge clk) disable iff (rst)
    phase == PH_STOP |-> !frame_ok)
    else $error("frame reported after a final error");

  a_two_results_need_end: assert property (@(posedge clk) disable iff (rst)
    n_push == 2'd2 |-> frame_ok && s_tlast && $past(q_count) <= QCNT_W'(Q_DEPTH))
    else $error("double push without end of buffer");

endmodule

[tb/rtcm3_frame_deframer_unit_tb.sv]
// Self-checking testbench for rtcm3_frame_deframer_unit: directed byte table, then random buffers.
// A behavioral deframer predicts every result beat; depends on rtcm3_dfr_pkg and the unit's RTL.
`timescale 1ns / 100ps

module rtcm3_frame_deframer_unit_tb;
  import rtcm3_dfr_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BEATS   = 170;
  localparam int NUM_PHASES    = 5;
  localparam int DIR_N         = 37;
  localparam logic [FRAME_COUNT_W-1:0] COUNT_CAP =
    (COUNT_BITS_DEF >= FRAME_COUNT_W) ? {FRAME_COUNT_W{1'b1}}
                                      : FRAME_COUNT_W'((1 << COUNT_BITS_DEF) - 1);

  // field positions in m_tdata
  localparam int MT_LSB  = LEN_W;
  localparam int CRC_LSB = MT_LSB + MSG_W;
  localparam int CNT_LSB = CRC_LSB + CRC_W;
  localparam int ERR_LSB = CNT_LSB + FRAME_COUNT_W;

  localparam logic [PADDR_W-1:0] ADDR_SYNC = {REG_SYNC_BYTE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_MAXL = {REG_MAX_LENGTH, 2'b00};

  typedef struct packed {
    logic                     kind;
    logic [LEN_W-1:0]         len;
    logic [MSG_W-1:0]         mt;
    logic [CRC_W-1:0]         crc;
    logic [FRAME_COUNT_W-1:0] cnt;
    err_t                     err;
    logic                     last;
  } report_t;

  // a done beat typed into the table replaces the predicted one
  typedef struct packed {
    logic                     pinned;
    logic [FRAME_COUNT_W-1:0] cnt;
    err_t                     err;
  } done_fix_t;

  typedef enum logic [1:0] {SRC_LIT, SRC_CRC_HI, SRC_CRC_MID, SRC_CRC_LO} byte_src_t;

  typedef struct packed {
    logic [BYTE_W-1:0]        val;
    byte_src_t                src;
    logic                     sof;
    logic                     eob;
    logic                     pinned;
    logic [FRAME_COUNT_W-1:0] cnt;
    err_t                     err;
  } dir_row_t;

  localparam done_fix_t NO_FIX = '0;

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [BYTE_W-1:0]   s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic                m_tuser;
  logic                m_tlast;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [PADDR_W-1:0]  paddr    = '0;
  logic [PDATA_W-1:0]  pwdata   = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  rtcm3_frame_deframer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // directed bytes: each buffer ends on a beat with tlast
  dir_row_t dir_rows [DIR_N] = '{
    // buffer of one byte: short wins over the bad preamble
    '{8'hFF, SRC_LIT,     1'b1, 1'b1, 1'b1, 16'd0, ERR_SHORT},
    // good frame, one payload byte, reserved length bits all set
    '{8'hD3, SRC_LIT,     1'b1, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'hFC, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h01, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h5A, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_CRC_HI,  1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_CRC_MID, 1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_CRC_LO,  1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    // longest length, buffer ends on the seventh byte: truncated
    '{8'hD3, SRC_LIT,     1'b1, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h03, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'hFF, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'hFF, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'hFF, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b1, 1'b1, 16'd1, ERR_TRUNC},
    // bad preamble held to the seventh byte, then an ignored byte
    '{8'hD2, SRC_LIT,     1'b1, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h01, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'hFF, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'hA5, SRC_LIT,     1'b0, 1'b1, 1'b1, 16'd0, ERR_PREAMBLE},
    // zero payload length
    '{8'hD3, SRC_LIT,     1'b1, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b1, 1'b1, 16'd0, ERR_LENGTH},
    // one-byte frame with a zero crc that does not match
    '{8'hD3, SRC_LIT,     1'b1, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h01, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b0, 1'b0, 16'd0, ERR_NONE},
    '{8'h00, SRC_LIT,     1'b0, 1'b1, 1'b1, 16'd0, ERR_CRC}
  };

  // deframer state as seen by the predictor
  logic                     scan_halted;
  logic [IDX_W-1:0]         scan_pos;
  logic [LEN_W-1:0]         frm_len;
  logic [CRC_W-1:0]         crc_calc;
  logic [CRC_W-1:0]         crc_rx;
  logic [MSG_W-1:0]         msg_id;
  logic [FRAME_COUNT_W-1:0] good_cnt;
  err_t                     held_err;
  logic [BYTE_W-1:0]        cfg_sync;
  logic [LEN_W-1:0]         cfg_maxlen;

  report_t    expected_reports[$];
  done_fix_t  done_fixes[$];
  logic [BYTE_W-1:0] frm_bytes[$];

  int  mismatches  = 0;
  int  cycles      = 0;
  int  sent_beats  = 0;
  int  tx_mode_left = 0;
  bit  tx_quiet    = 1'b0;
  int  rx_mode_left = 0;
  bit  rx_quiet    = 1'b0;
  int  rx_stall    = 0;
  int  rx_pick;
  bit  big_frame_due = 1'b0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // crc-24q, one bit at a time, msb first
  function automatic logic [CRC_W-1:0] crc24q_step(input logic [CRC_W-1:0] c,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    logic             fb;
    r = c;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = r[CRC_W-1] ^ b[i];
      r  = {r[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return r;
  endfunction

  function automatic void clear_frame();
    scan_pos = '0;
    frm_len  = '0;
    crc_calc = '0;
    crc_rx   = '0;
    msg_id   = '0;
    held_err = ERR_NONE;
  endfunction

  function automatic void clear_buffer();
    clear_frame();
    scan_halted = 1'b0;
    good_cnt    = '0;
  endfunction

  // one accepted byte through the deframer, queuing the beats it yields
  task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic eob, output int produced);
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] body;
    err_t             code;
    report_t          rep;
    produced = 0;
    if (!scan_halted) begin
      pos  = scan_pos;
      body = HDR_BYTES + frm_len;
      if (pos == IDX_PREAMBLE) begin
        if (b != cfg_sync) held_err = ERR_PREAMBLE;
      end else if (pos == IDX_LEN_HI) begin
        frm_len = {b[1:0], 8'h00};
      end else if (pos == IDX_LEN_LO) begin
        frm_len[7:0] = b;
        if (held_err == ERR_NONE && (frm_len == 0 || frm_len > cfg_maxlen))
          held_err = ERR_LENGTH;
        body = HDR_BYTES + frm_len;
      end
      // header and payload feed the crc, the rest is the received crc
      if (pos < HDR_BYTES || pos < body) begin
        crc_calc = crc24q_step(crc_calc, b);
        if (pos == IDX_MSG_HI) msg_id = {b, 4'h0};
        else if (pos == IDX_MSG_LO) msg_id[3:0] = b[7:4];
      end else begin
        crc_rx = {crc_rx[CRC_W-9:0], b};
      end
      scan_pos = pos + 1'b1;
      if (scan_pos == MIN_FRAME && held_err != ERR_NONE) begin
        scan_halted = 1'b1;
      end else if (held_err == ERR_NONE && scan_pos >= HDR_BYTES &&
                   scan_pos == OVERHEAD + frm_len) begin
        if (crc_rx == crc_calc) begin
          if (good_cnt < COUNT_CAP) good_cnt++;
          rep = '{KIND_FRAME, frm_len, (frm_len >= 2) ? msg_id : '0,
                  crc_rx, good_cnt, ERR_NONE, !eob};
          expected_reports.insert(expected_reports.size(), rep);
          produced++;
          clear_frame();
        end else begin
          held_err    = ERR_CRC;
          scan_halted = 1'b1;
        end
      end
    end
    // end of buffer: summary beat, then a fresh buffer
    if (eob) begin
      if (scan_halted) code = held_err;
      else if (scan_pos == 0) code = ERR_NONE;
      else if (scan_pos < MIN_FRAME) code = ERR_SHORT;
      else code = ERR_TRUNC;
      rep = '{KIND_DONE, '0, '0, '0, good_cnt, code, 1'b1};
      expected_reports.insert(expected_reports.size(), rep);
      produced++;
      clear_buffer();
    end
  endtask

  task automatic compare_field(input string fname, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    report_t want;
    report_t got;
    got.kind = m_tuser;
    got.len  = m_tdata[LEN_W-1:0];
    got.mt   = m_tdata[MT_LSB +: MSG_W];
    got.crc  = m_tdata[CRC_LSB +: CRC_W];
    got.cnt  = m_tdata[CNT_LSB +: FRAME_COUNT_W];
    got.err  = err_t'(m_tdata[ERR_LSB +: ERR_W]);
    got.last = m_tlast;
    if (expected_reports.size() == 0) begin
      $display("%0t: result beat with nothing expected, expected none got tuser %0b tdata %h",
               $time, m_tuser, m_tdata);
      mismatches++;
    end else begin
      want = expected_reports.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("payload_length", want.len, got.len);
      compare_field("msg_type", want.mt, got.mt);
      compare_field("frame_crc", want.crc, got.crc);
      compare_field("frame_count", want.cnt, got.cnt);
      compare_field("error_code", want.err, got.err);
      compare_field("last_result", want.last, got.last);
    end
  endtask

  // result beats are checked before the byte of the same edge is predicted
  always @(posedge clk) begin
    int        produced;
    done_fix_t fix;
    report_t   rep;
    if (!rst) begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) begin
        fix = done_fixes.pop_front();
        predict_byte(s_tdata, s_tlast, produced);
        if (fix.pinned) begin
          repeat (produced) void'(expected_reports.pop_back());
          rep = '{KIND_DONE, '0, '0, '0, fix.cnt, fix.err, 1'b1};
          expected_reports.insert(expected_reports.size(), rep);
        end
      end
    end
  end

  // receiver: stretches of full rate, otherwise short and long stalls
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_quiet     = ($urandom_range(0, 3) == 0);
      rx_mode_left = $urandom_range(40, 300);
    end
    rx_mode_left--;
    if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else if (rx_quiet) begin
      m_tready <= 1'b1;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 65) begin
        m_tready <= 1'b1;
      end else begin
        rx_stall = (rx_pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        m_tready <= 1'b0;
      end
    end
  end

  function automatic int next_gap();
    int pick;
    if (tx_mode_left == 0) begin
      tx_quiet     = ($urandom_range(0, 3) == 0);
      tx_mode_left = $urandom_range(30, 200);
    end
    tx_mode_left--;
    if (tx_quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called and returns at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eob, input done_fix_t fix);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    done_fixes.insert(done_fixes.size(), fix);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eob;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_beats++;
    @(negedge clk);
  endtask

  // hold the sender until every expected beat is out, then let the pipe settle
  task automatic wait_for_reports();
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one apb transfer, psel left high for the next one
  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (!wr && prdata !== data) begin
      $display("%0t: register at %0h expected %0h got %0h", $time, addr, data, prdata);
      mismatches++;
    end
    @(negedge clk);
  endtask

  task automatic set_registers(input logic [BYTE_W-1:0] sync, input logic [LEN_W-1:0] maxl);
    apb_access(1'b1, ADDR_SYNC, PDATA_W'(sync));
    apb_access(1'b1, ADDR_MAXL, PDATA_W'(maxl));
    apb_access(1'b0, ADDR_SYNC, PDATA_W'(sync));
    apb_access(1'b0, ADDR_MAXL, PDATA_W'(maxl));
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_sync   = sync;
    cfg_maxlen = maxl;
    @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return BYTE_W'($urandom);
  endfunction

  // mostly well-formed frames; some bad preambles, lengths and crcs
  task automatic build_frame();
    logic [LEN_W-1:0] len;
    logic [CRC_W-1:0] crc;
    int               pick;
    int               hi;
    pick = $urandom_range(0, 99);
    if (big_frame_due && cfg_maxlen >= 200) begin
      len = cfg_maxlen;
      big_frame_due = 1'b0;
    end else if (pick < 3) begin
      len = '0;
    end else if (pick < 8 && cfg_maxlen < 1023) begin
      hi  = (cfg_maxlen + 20 > 1023) ? 1023 : cfg_maxlen + 20;
      len = LEN_W'($urandom_range(cfg_maxlen + 1, hi));
    end else begin
      hi  = (cfg_maxlen == 0 || cfg_maxlen > 12) ? 12 : cfg_maxlen;
      len = LEN_W'($urandom_range(1, hi));
    end
    frm_bytes = {};
    if ($urandom_range(0, 29) == 0)
      frm_bytes.insert(frm_bytes.size(), cfg_sync ^ BYTE_W'($urandom_range(1, 255)));
    else
      frm_bytes.insert(frm_bytes.size(), cfg_sync);
    frm_bytes.insert(frm_bytes.size(), {6'($urandom), len[9:8]});
    frm_bytes.insert(frm_bytes.size(), len[7:0]);
    for (int i = 0; i < len; i++) frm_bytes.insert(frm_bytes.size(), pick_byte());
    crc = '0;
    foreach (frm_bytes[i]) crc = crc24q_step(crc, frm_bytes[i]);
    if ($urandom_range(0, 29) == 0) crc ^= CRC_W'(1) << $urandom_range(0, CRC_W - 1);
    frm_bytes.insert(frm_bytes.size(), crc[23:16]);
    frm_bytes.insert(frm_bytes.size(), crc[15:8]);
    frm_bytes.insert(frm_bytes.size(), crc[7:0]);
  endtask

  // a buffer of back-to-back frames, sometimes cut short or with trailing noise
  task automatic send_random_buffer();
    logic [BYTE_W-1:0] buf_bytes[$];
    int                nfr;
    int                cut;
    nfr = $urandom_range(0, 4);
    for (int i = 0; i < nfr; i++) begin
      build_frame();
      buf_bytes = {buf_bytes, frm_bytes};
    end
    if ($urandom_range(0, 6) == 0) begin
      build_frame();
      cut = $urandom_range(1, frm_bytes.size() - 1);
      for (int i = 0; i < cut; i++) buf_bytes.insert(buf_bytes.size(), frm_bytes[i]);
    end
    if ($urandom_range(0, 9) == 0 || buf_bytes.size() == 0) begin
      repeat ($urandom_range(1, 6)) buf_bytes.insert(buf_bytes.size(), BYTE_W'($urandom));
    end
    foreach (buf_bytes[k]) send_byte(buf_bytes[k], k == buf_bytes.size() - 1, NO_FIX);
  endtask

  initial begin
    logic [CRC_W-1:0]  tx_crc;
    logic [BYTE_W-1:0] val;
    done_fix_t         fix;
    int                phase_start;
    cfg_sync   = SYNC_BYTE_RST;
    cfg_maxlen = MAX_LENGTH_RST;
    clear_buffer();
    tx_crc = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed bytes at the reset register values
    foreach (dir_rows[i]) begin
      if (dir_rows[i].sof) tx_crc = '0;
      case (dir_rows[i].src)
        SRC_CRC_HI:  val = tx_crc[23:16];
        SRC_CRC_MID: val = tx_crc[15:8];
        SRC_CRC_LO:  val = tx_crc[7:0];
        default: begin
          val    = dir_rows[i].val;
          tx_crc = crc24q_step(tx_crc, val);
        end
      endcase
      fix = '{dir_rows[i].pinned, dir_rows[i].cnt, dir_rows[i].err};
      send_byte(val, dir_rows[i].eob, fix);
    end
    wait_for_reports();

    // random buffers under several register settings
    for (int p = 1; p <= NUM_PHASES; p++) begin
      case (p)
        1: set_registers(8'h00, 10'd1);
        2: begin
          set_registers(8'hFF, 10'd200);
          big_frame_due = 1'b1;
        end
        3: set_registers(BYTE_W'($urandom), 10'd0);
        4: set_registers(BYTE_W'($urandom), LEN_W'($urandom_range(2, 40)));
        default: set_registers(SYNC_BYTE_RST, MAX_LENGTH_RST);
      endcase
      phase_start = sent_beats;
      while (sent_beats - phase_start < PHASE_BEATS) begin
        send_random_buffer();
        if ($urandom_range(0, 19) == 0) wait_for_reports();
      end
      wait_for_reports();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
